// ----- src/cm3_pkg.sv -----
// ----------------------------------------------------------------------------
// cm3_pkg: shared types and constants of the 3x3 Cramer solver
// Coefficient and result types, internal widths and the pipeline latency.
// ----------------------------------------------------------------------------
package cm3_pkg;

	// coefficient width, signed Q8.8
	localparam int COEF_WIDTH = 16;
	// determinant width: sum of six triple products plus margin
	localparam int DET_W = 3 * COEF_WIDTH + 2;
	// fraction bits added to the quotient
	localparam int FRAC_W = 16;
	// solution width, signed Q16.16
	localparam int SOL_W = 32;
	// stages: determinant 5, divider 2 + one per numerator bit, output 1
	localparam int DET_STAGES = 5;
	localparam int DIV_STAGES = DET_W + FRAC_W + 2;
	localparam int LATENCY = DET_STAGES + DIV_STAGES + 1;

	typedef logic signed [COEF_WIDTH-1:0] coef_t;
	typedef coef_t mat_t [9];

	typedef struct packed {
		coef_t a11;
		coef_t a12;
		coef_t a13;
		coef_t a21;
		coef_t a22;
		coef_t a23;
		coef_t a31;
		coef_t a32;
		coef_t a33;
		coef_t b1;
		coef_t b2;
		coef_t b3;
	} sys_t;

	typedef struct packed {
		logic                    singular;
		logic                    overflow;
		logic signed [SOL_W-1:0] sol_x;
		logic signed [SOL_W-1:0] sol_y;
		logic signed [SOL_W-1:0] sol_z;
	} sol_t;

	// status and value of one divider lane
	typedef struct packed {
		logic                    zero;
		logic                    sat;
		logic signed [SOL_W-1:0] val;
	} div_res_t;

endpackage

// ----- src/cramer_3x3_solver_unit.sv -----
// ----------------------------------------------------------------------------
// cramer_3x3_solver_unit: 3x3 linear system solver by Cramer's rule
// The path from start to done runs through the determinant stages, the divider stages and the output register.
// Throughput: one system per cycle; busy stays low, results cannot be stalled.
// The rate is set by the fully pipelined determinant and divider stages.
// Reset clears the valid bits only; no state is kept between systems.
// ----------------------------------------------------------------------------
module cramer_3x3_solver_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cm3_pkg::sys_t     sys,
	output logic              done,
	output cm3_pkg::sol_t     sol
);

	localparam int DW = cm3_pkg::DET_W;

	cm3_pkg::mat_t            mat [4];
	logic                     det_vld [4];
	logic signed [DW-1:0]     det [4];
	logic                     div_vld [3];
	cm3_pkg::div_res_t        div_res [3];
	logic                     done_q;
	cm3_pkg::sol_t            sol_q;

	// main matrix and the three column-replaced matrices
	assign mat[0] = '{sys.a11, sys.a12, sys.a13, sys.a21, sys.a22, sys.a23,
		sys.a31, sys.a32, sys.a33};
	assign mat[1] = '{sys.b1, sys.a12, sys.a13, sys.b2, sys.a22, sys.a23,
		sys.b3, sys.a32, sys.a33};
	assign mat[2] = '{sys.a11, sys.b1, sys.a13, sys.a21, sys.b2, sys.a23,
		sys.a31, sys.b3, sys.a33};
	assign mat[3] = '{sys.a11, sys.a12, sys.b1, sys.a21, sys.a22, sys.b2,
		sys.a31, sys.a32, sys.b3};

	// determinants
	for (genvar m = 0; m < 4; m++) begin : g_det
		cm3_det u_det (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (start),
			.mat     (mat[m]),
			.vld_out (det_vld[m]),
			.det     (det[m])
		);
	end

	// quotients
	for (genvar c = 0; c < 3; c++) begin : g_div
		cm3_div u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (det_vld[c+1]),
			.num     (det[c+1]),
			.den     (det[0]),
			.vld_out (div_vld[c]),
			.res     (div_res[c])
		);
	end

	// output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld[0];
		end
	end

	// output register, singular systems give zeros
	always_ff @(posedge clk) begin
		sol_q.singular <= div_res[0].zero;
		sol_q.overflow <= !div_res[0].zero
			&& (div_res[0].sat || div_res[1].sat || div_res[2].sat);
		sol_q.sol_x    <= div_res[0].zero ? '0 : div_res[0].val;
		sol_q.sol_y    <= div_res[0].zero ? '0 : div_res[1].val;
		sol_q.sol_z    <= div_res[0].zero ? '0 : div_res[2].val;
	end

	assign busy = 1'b0;
	assign done = done_q;
	assign sol  = sol_q;

endmodule

// ----- src/cm3_det.sv -----
// ----------------------------------------------------------------------------
// cm3_det: pipelined 3x3 determinant
// Rule of Sarrus over five stages: pair products, split third products,
// term assembly, partial sums, final difference.
// ----------------------------------------------------------------------------
module cm3_det (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               vld_in,
	input  cm3_pkg::mat_t                      mat,
	output logic                               vld_out,
	output logic signed [cm3_pkg::DET_W-1:0]   det
);

	localparam int W  = cm3_pkg::COEF_WIDTH;
	localparam int DW = cm3_pkg::DET_W;

	// Sarrus terms: first three added, last three subtracted
	localparam int TI [6] = '{0, 1, 2, 2, 1, 0};
	localparam int TJ [6] = '{4, 5, 3, 4, 3, 5};
	localparam int TK [6] = '{8, 6, 7, 6, 8, 7};

	logic                      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [2*W-1:0]     pp_s1 [6];
	cm3_pkg::coef_t            c_s1 [6];
	logic signed [2*W-1:0]     hi_s2 [6];
	logic signed [2*W:0]       lo_s2 [6];
	logic signed [3*W-1:0]     term_s3 [6];
	logic signed [DW-1:0]      pos_s4, neg_s4;
	logic signed [DW-1:0]      det_s5;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		for (int t = 0; t < 6; t++) begin
			// pair product, third factor carried
			pp_s1[t] <= $signed(mat[TI[t]]) * $signed(mat[TJ[t]]);
			c_s1[t]  <= mat[TK[t]];
			// third factor on upper and lower halves of the pair product
			hi_s2[t] <= $signed(pp_s1[t][2*W-1:W]) * $signed(c_s1[t]);
			lo_s2[t] <= $signed({1'b0, pp_s1[t][W-1:0]}) * $signed(c_s1[t]);
			// recombine
			term_s3[t] <= $signed({hi_s2[t], {W{1'b0}}})
				+ $signed({{(W-1){lo_s2[t][2*W]}}, lo_s2[t]});
		end
		pos_s4 <= DW'(term_s3[0]) + DW'(term_s3[1]) + DW'(term_s3[2]);
		neg_s4 <= DW'(term_s3[3]) + DW'(term_s3[4]) + DW'(term_s3[5]);
		det_s5 <= pos_s4 - neg_s4;
	end

	assign vld_out = vld_s5;
	assign det     = det_s5;

endmodule

// ----- src/cm3_div.sv -----
// ----------------------------------------------------------------------------
// cm3_div: pipelined signed Q16.16 divider with saturation
// One restoring step per stage over every numerator bit, then sign and
// saturation; quotient is truncated toward zero.
// ----------------------------------------------------------------------------
module cm3_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               vld_in,
	input  logic signed [cm3_pkg::DET_W-1:0]   num,
	input  logic signed [cm3_pkg::DET_W-1:0]   den,
	output logic                               vld_out,
	output cm3_pkg::div_res_t                  res
);

	localparam int DW = cm3_pkg::DET_W;
	localparam int NW = cm3_pkg::DET_W + cm3_pkg::FRAC_W;
	localparam int QW = cm3_pkg::SOL_W + 1;
	localparam logic [QW-1:0] LIM_POS = {2'b00, {(QW-2){1'b1}}};
	localparam logic [QW-1:0] LIM_NEG = {2'b01, {(QW-2){1'b0}}};

	// stage k of the step chain holds the state before step k
	logic            vld_s  [NW+1];
	logic            neg_s  [NW+1];
	logic            zero_s [NW+1];
	logic [NW-1:0]   num_s  [NW+1];
	logic [DW-1:0]   den_s  [NW+1];
	logic [DW-1:0]   rem_s  [NW+1];
	logic [QW-1:0]   q_s    [NW+1];
	logic            hi_s   [NW+1];

	logic                        vld_q;
	cm3_pkg::div_res_t           res_q;
	logic [QW-1:0]               lim;
	logic                        sat;
	logic [QW-1:0]               mag;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NW; k++) vld_s[k] <= 1'b0;
			vld_q <= 1'b0;
		end else begin
			vld_s[0] <= vld_in;
			for (int k = 0; k < NW; k++) vld_s[k+1] <= vld_s[k];
			vld_q <= vld_s[NW];
		end
	end

	// operand prep: magnitudes, sign, shifted numerator
	always_ff @(posedge clk) begin
		neg_s[0]  <= num[DW-1] ^ den[DW-1];
		zero_s[0] <= (den == '0);
		num_s[0]  <= {(num[DW-1] ? DW'(-num) : DW'(num)), {cm3_pkg::FRAC_W{1'b0}}};
		den_s[0]  <= den[DW-1] ? DW'(-den) : DW'(den);
		rem_s[0]  <= '0;
		q_s[0]    <= '0;
		hi_s[0]   <= 1'b0;
	end

	// restoring steps, one quotient bit per stage
	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [DW:0] trial;
		logic        ge;
		assign trial = {rem_s[k], num_s[k][NW-1]};
		assign ge    = (trial >= {1'b0, den_s[k]});
		always_ff @(posedge clk) begin
			neg_s[k+1]  <= neg_s[k];
			zero_s[k+1] <= zero_s[k];
			den_s[k+1]  <= den_s[k];
			num_s[k+1]  <= {num_s[k][NW-2:0], 1'b0};
			rem_s[k+1]  <= ge ? DW'(trial - {1'b0, den_s[k]}) : trial[DW-1:0];
			q_s[k+1]    <= {q_s[k][QW-2:0], ge};
			hi_s[k+1]   <= hi_s[k] | q_s[k][QW-1];
		end
	end

	// saturation and sign
	assign lim = neg_s[NW] ? LIM_NEG : LIM_POS;
	assign sat = hi_s[NW] || (q_s[NW] > lim);
	assign mag = sat ? lim : q_s[NW];

	always_ff @(posedge clk) begin
		res_q.zero <= zero_s[NW];
		res_q.sat  <= sat;
		res_q.val  <= neg_s[NW] ? cm3_pkg::SOL_W'(-mag) : mag[cm3_pkg::SOL_W-1:0];
	end

	assign vld_out = vld_q;
	assign res     = res_q;

endmodule

// ----- src/cm3_chk.sv -----
// ----------------------------------------------------------------------------
// cm3_chk: port-level checks of the 3x3 Cramer solver
// Timing of the result strobe, absence of back-pressure, known systems on transfer and consistency of the result flags.
// ----------------------------------------------------------------------------
module cm3_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input cm3_pkg::sys_t     sys,
	input logic              done,
	input cm3_pkg::sol_t     sol
);

	// every result comes from a transfer a fixed latency earlier
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, cm3_pkg::LATENCY))
		else $error("result without matching transfer");

	// pipeline never pushes back
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// singular system gives zero solutions and no overflow
	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		(done && sol.singular) |-> (!sol.overflow && sol.sol_x == '0
			&& sol.sol_y == '0 && sol.sol_z == '0))
		else $error("singular result not cleared");

	// overflow means at least one solution sits at a limit
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(done && sol.overflow) |->
			(sol.sol_x == 32'sh7FFFFFFF || sol.sol_x == 32'sh80000000
			|| sol.sol_y == 32'sh7FFFFFFF || sol.sol_y == 32'sh80000000
			|| sol.sol_z == 32'sh7FFFFFFF || sol.sol_z == 32'sh80000000))
		else $error("overflow without saturated solution");

	// a system is checked only through its fields; keep sys observed
	a_sys_known: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !$isunknown(sys))
		else $error("unknown system on transfer");

endmodule

bind cramer_3x3_solver_unit cm3_chk u_cm3_chk (.*);

// ----- dv/tb_cramer_3x3_solver_unit.sv -----
// ----------------------------------------------------------------------------
// tb_cramer_3x3_solver_unit: self-checking testbench of the 3x3 Cramer solver
// A directed table of systems (identity, zero, saturating, extreme values)
// followed by random systems sent in bursts with random gaps. Every result is
// compared field by field with a scoreboard fed by the table or a behavioral solver.
// ----------------------------------------------------------------------------
module tb_cramer_3x3_solver_unit;

	localparam int N_RANDOM  = 1300;
	localparam int CYC_LIMIT = 400000;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	logic           busy;
	cm3_pkg::sys_t  sys = '0;
	logic           done;
	cm3_pkg::sol_t  sol;

	cm3_pkg::sol_t  sol_fifo[$];
	int             n_errors = 0;
	int             cyc = 0;

	cramer_3x3_solver_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sys    (sys),
		.done   (done),
		.sol    (sol)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYC_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cyc);
		n_errors++;
	endtask

	// Sarrus determinant of a row-major 3x3 matrix, exact
	function automatic logic signed [63:0] det_sarrus(input logic signed [63:0] m [9]);
		return m[0]*m[4]*m[8] + m[1]*m[5]*m[6] + m[2]*m[3]*m[7]
		     - m[2]*m[4]*m[6] - m[1]*m[3]*m[8] - m[0]*m[5]*m[7];
	endfunction

	// num * 2^16 / den, truncated toward zero, saturated to Q16.16
	function automatic logic [31:0] div_q16(input logic signed [63:0] num,
		input logic signed [63:0] den, inout logic sat);
		logic [63:0]  nmag, dmag;
		logic [127:0] q, lim;
		logic         neg;
		nmag = (num < 0) ? -num : num;
		dmag = (den < 0) ? -den : den;
		neg  = (num < 0) != (den < 0);
		q    = ({64'd0, nmag} << 16) / {64'd0, dmag};
		lim  = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (q > lim) begin
			sat = 1'b1;
			q   = lim;
		end
		return neg ? (32'd0 - q[31:0]) : q[31:0];
	endfunction

	function automatic cm3_pkg::sol_t solve_system(input cm3_pkg::sys_t s);
		logic signed [63:0] a [9];
		logic signed [63:0] bv [3];
		logic signed [63:0] m [9];
		logic signed [63:0] dmain;
		logic [31:0]        v [3];
		logic               sat;
		cm3_pkg::sol_t      r;
		a = '{s.a11, s.a12, s.a13, s.a21, s.a22, s.a23, s.a31, s.a32, s.a33};
		bv = '{s.b1, s.b2, s.b3};
		sat = 1'b0;
		r = '0;
		dmain = det_sarrus(a);
		if (dmain == 0) begin
			r.singular = 1'b1;
			return r;
		end
		for (int col = 0; col < 3; col++) begin
			m = a;
			for (int i = 0; i < 3; i++)
				m[i*3 + col] = bv[i];
			v[col] = div_q16(det_sarrus(m), dmain, sat);
		end
		r.overflow = sat;
		r.sol_x = v[0];
		r.sol_y = v[1];
		r.sol_z = v[2];
		return r;
	endfunction

	// result check against the oldest expectation
	always @(posedge clk) begin
		cm3_pkg::sol_t want;
		if (arst_n && done) begin
			if (sol_fifo.size() == 0) begin
				report_mismatch("unexpected result", sol.sol_x, 32'd0);
			end else begin
				want = sol_fifo.pop_front();
				if (sol.singular !== want.singular)
					report_mismatch("singular", 32'(sol.singular), 32'(want.singular));
				if (sol.overflow !== want.overflow)
					report_mismatch("overflow", 32'(sol.overflow), 32'(want.overflow));
				if (sol.sol_x !== want.sol_x) report_mismatch("sol_x", sol.sol_x, want.sol_x);
				if (sol.sol_y !== want.sol_y) report_mismatch("sol_y", sol.sol_y, want.sol_y);
				if (sol.sol_z !== want.sol_z) report_mismatch("sol_z", sol.sol_z, want.sol_z);
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_system(input cm3_pkg::sys_t v, input bit typed,
		input cm3_pkg::sol_t typed_sol);
		start <= 1'b1;
		sys   <= v;
		do @(posedge clk); while (busy);
		sol_fifo.push_back(typed ? typed_sol : solve_system(v));
		@(negedge clk);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		sys   <= cm3_pkg::sys_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom});
		repeat (n) @(negedge clk);
	endtask

	function automatic cm3_pkg::coef_t rand_coef(input int mode);
		case (mode)
			0: return cm3_pkg::coef_t'($urandom);
			1: return cm3_pkg::coef_t'($urandom_range(0, 1024) - 512);
			default: return cm3_pkg::coef_t'($urandom_range(0, 8) - 4) <<< 8;
		endcase
	endfunction

	typedef struct {
		cm3_pkg::sys_t v;
		bit            typed;
		cm3_pkg::sol_t want;
	} dir_row_t;

	dir_row_t dir_tab [$];

	initial begin
		cm3_pkg::sys_t v;
		int            burst, mode;

		// directed stimulus
		// identity with b = 1, 2, 3
		v = '0; v.a11 = 256; v.a22 = 256; v.a33 = 256; v.b1 = 256; v.b2 = 512; v.b3 = 768;
		dir_tab.push_back('{v, 1, '{1'b0, 1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000}});
		// zero matrix: singular
		v = '0; v.b1 = 16'h7FFF;
		dir_tab.push_back('{v, 1, '{1'b1, 1'b0, 32'd0, 32'd0, 32'd0}});
		// all most negative: rank one, singular
		v = {12{16'h8000}};
		dir_tab.push_back('{v, 1, '{1'b1, 1'b0, 32'd0, 32'd0, 32'd0}});
		// all most positive: singular
		v = {12{16'h7FFF}};
		dir_tab.push_back('{v, 1, '{1'b1, 1'b0, 32'd0, 32'd0, 32'd0}});
		// positive saturation of x
		v = '0; v.a11 = 1; v.a12 = -32768; v.a22 = 1; v.a33 = 1; v.b1 = 32767; v.b2 = 32767;
		dir_tab.push_back('{v, 1, '{1'b0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_0000, 32'd0}});
		// negative saturation of x
		v.b2 = -32767;
		dir_tab.push_back('{v, 1, '{1'b0, 1'b1, 32'h8000_0000, 32'h8001_0000, 32'd0}});
		// truncation toward zero: 1/3 and -1/3
		v = '0; v.a11 = 768; v.a22 = 768; v.a33 = 768; v.b1 = 256; v.b2 = -256; v.b3 = 0;
		dir_tab.push_back('{v, 0, '0});
		// most negative on the diagonal, extreme constants
		v = '0; v.a11 = -32768; v.a22 = -32768; v.a33 = -32768;
		v.b1 = 32767; v.b2 = -32768; v.b3 = 1;
		dir_tab.push_back('{v, 0, '0});
		// diagonal of 1, -1, 1 (raw) with extreme constants
		v = '0; v.a11 = 1; v.a22 = -1; v.a33 = 1; v.b1 = -32768; v.b2 = -32768; v.b3 = 32767;
		dir_tab.push_back('{v, 0, '0});
		// dense extreme mix
		v = {16'h7FFF, 16'h8000, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF,
		     16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000};
		dir_tab.push_back('{v, 0, '0});
		for (int i = 0; i < 6; i++) begin
			v = cm3_pkg::sys_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom});
			dir_tab.push_back('{v, 0, '0});
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			send_system(dir_tab[i].v, dir_tab[i].typed, dir_tab[i].want);
			if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 3));
		end

		// random systems in bursts
		burst = 0;
		for (int i = 0; i < N_RANDOM; i++) begin
			mode = $urandom_range(0, 2);
			for (int k = 0; k < 12; k++)
				v[k*16 +: 16] = rand_coef(mode);
			// make some systems singular by repeating a row or zeroing a column
			case ($urandom_range(0, 9))
				0: {v.a31, v.a32, v.a33} = {v.a11, v.a12, v.a13};
				1: {v.a12, v.a22, v.a32} = '0;
				default: ;
			endcase
			send_system(v, 0, '0);
			burst++;
			if (i == N_RANDOM / 2) begin
				// hold off until every expected result is in
				start <= 1'b0;
				while (sol_fifo.size() != 0) @(negedge clk);
				burst = 0;
			end else if (burst >= $urandom_range(1, 40)) begin
				idle_cycles($urandom_range(1, 12));
				burst = 0;
			end
		end
		start <= 1'b0;

		while (sol_fifo.size() != 0) @(posedge clk);
		repeat (cm3_pkg::LATENCY + 10) @(posedge clk);
		if (n_errors == 0 && sol_fifo.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
